FILE: rtl/ppp_pkg.sv
// Package for the perspective point projection block.
// Types, widths and register codes shared by ppp_xform, ppp_div and the top level.
package ppp_pkg;

	localparam int IN_W       = 24;
	localparam int TRIG_W     = 16;
	localparam int TRACK_W    = 23;
	localparam int SXY_W      = 20;
	localparam int HW_W       = 19;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int T_W    = 42;  // rotated coordinates, Q.14
	localparam int DEN_W  = 42;
	localparam int NUM_W  = 64;
	localparam int QB     = 22;  // quotient bits of 2*n/d
	localparam int RW     = 66;
	localparam int NL     = 3;   // lanes: x, y, half width
	localparam int SUM_W  = 24;

	localparam int LANE_X = 0;
	localparam int LANE_Y = 1;
	localparam int LANE_W = 2;

	localparam int XF_STAGES  = 4;
	localparam int DIV_STAGES = QB + 1;
	localparam int NS         = XF_STAGES + DIV_STAGES + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAMERA_X = 3'd0,
		REG_CAMERA_Y = 3'd1,
		REG_CAMERA_Z = 3'd2,
		REG_SINE     = 3'd3,
		REG_COSINE   = 3'd4,
		REG_TRACK    = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic signed [IN_W-1:0]   camera_x;
		logic signed [IN_W-1:0]   camera_y;
		logic signed [IN_W-1:0]   camera_z;
		logic signed [TRIG_W-1:0] sine;
		logic signed [TRIG_W-1:0] cosine;
		logic [TRACK_W-1:0]       lap_length;
	} cfg_t;

	typedef struct packed {
		logic [NL-1:0][NUM_W-1:0] num;
		logic [DEN_W-1:0]         den;
		logic                     neg_x;
		logic                     neg_y;
		logic                     clamped;
	} xf_t;

	typedef struct packed {
		logic [NL-1:0][QB-1:0] quo;
		logic [NL-1:0]         ovf;
		logic                  neg_x;
		logic                  neg_y;
		logic                  clamped;
	} dv_t;

endpackage

FILE: rtl/ppp_xform.sv
// Camera transform: offset, heading rotation, near clamp and numerator build.
// Four register stages; depends on ppp_pkg.
module ppp_xform import ppp_pkg::*; #(
	parameter int SCREEN_WIDTH    = 320,
	parameter int SCREEN_HEIGHT   = 240,
	parameter int ROAD_HALF_WIDTH = 2048
) (
	input  logic                   clk,
	input  logic [XF_STAGES-1:0]   en,
	input  cfg_t                   cfg,
	input  logic signed [IN_W-1:0] world_x,
	input  logic signed [IN_W-1:0] world_y,
	input  logic signed [IN_W-1:0] world_z,
	input  logic                   wrap_back,
	output xf_t                    xf_s4
);

	localparam logic [19:0] KX1  = 20'(16 * SCREEN_WIDTH);
	localparam logic [19:0] KX10 = 20'(160 * SCREEN_WIDTH);
	localparam logic [19:0] KY1  = 20'(16 * SCREEN_HEIGHT);
	localparam logic [19:0] KY10 = 20'(160 * SCREEN_HEIGHT);
	localparam longint      KW_L = longint'(16) * longint'(SCREEN_WIDTH)
		* longint'(ROAD_HALF_WIDTH) * longint'(16384);
	localparam logic [NUM_W-1:0] KW1  = NUM_W'(KW_L);
	localparam logic [NUM_W-1:0] KW10 = NUM_W'(KW_L * 10);

	logic signed [24:0] cz_eff;
	logic signed [24:0] dx_s1, dy_s1;
	logic signed [25:0] dz_s1;
	logic signed [40:0] p_xc_s2, p_xs_s2;
	logic signed [41:0] p_zc_s2, p_zs_s2;
	logic signed [24:0] dy_s2, dy_s3;
	logic signed [T_W-1:0] tx_s3, tz_s3;
	logic signed [45:0] tz10;
	logic clamp;
	logic [T_W-1:0] mag_tx;
	logic [24:0] mag_dy;
	logic [19:0] kx, ky;

	assign cz_eff = 25'(cfg.camera_z)
		- $signed({2'b00, cfg.lap_length & {TRACK_W{wrap_back}}});

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= 25'(world_x) - 25'(cfg.camera_x);
			dy_s1 <= 25'(world_y) - 25'(cfg.camera_y);
			dz_s1 <= 26'(world_z) - 26'(cz_eff);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			p_xc_s2 <= 41'(dx_s1) * 41'(cfg.cosine);
			p_xs_s2 <= 41'(dx_s1) * 41'(cfg.sine);
			p_zc_s2 <= 42'(dz_s1) * 42'(cfg.cosine);
			p_zs_s2 <= 42'(dz_s1) * 42'(cfg.sine);
			dy_s2   <= dy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			tx_s3 <= T_W'(p_xc_s2) + T_W'(p_zs_s2);
			tz_s3 <= T_W'(p_zc_s2) - T_W'(p_xs_s2);
			dy_s3 <= dy_s2;
		end
	end

	always_comb begin
		tz10   = 46'(tz_s3) * 46'sd10;
		clamp  = tz10 < 46'sd16384;
		mag_tx = tx_s3[T_W-1] ? T_W'(-tx_s3) : T_W'(tx_s3);
		mag_dy = dy_s3[24] ? 25'(-dy_s3) : 25'(dy_s3);
		kx     = clamp ? KX10 : KX1;
		ky     = clamp ? KY10 : KY1;
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			xf_s4.num[LANE_X] <= NUM_W'(mag_tx) * NUM_W'(kx);
			xf_s4.num[LANE_Y] <= (NUM_W'(mag_dy) * NUM_W'(ky)) << 14;
			xf_s4.num[LANE_W] <= clamp ? KW10 : KW1;
			xf_s4.den         <= clamp ? DEN_W'(16384) : DEN_W'(tz_s3);
			xf_s4.neg_x       <= tx_s3[T_W-1];
			xf_s4.neg_y       <= dy_s3[24];
			xf_s4.clamped     <= clamp;
		end
	end

endmodule

FILE: rtl/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, three lanes on one divisor.
// Gives floor(num/den) with an overflow flag; depends on ppp_pkg.
module ppp_div import ppp_pkg::*; (
	input  logic                  clk,
	input  logic [DIV_STAGES-1:0] en,
	input  xf_t                   xf,
	output dv_t                   dv
);

	logic [NL-1:0][RW-1:0] rem_s [DIV_STAGES];
	logic [NL-1:0][QB-1:0] quo_s [DIV_STAGES];
	logic [NL-1:0]         ovf_s [DIV_STAGES];
	logic [DEN_W-1:0]      den_s [DIV_STAGES];
	logic [2:0]            flg_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int l = 0; l < NL; l++) begin
				rem_s[0][l] <= RW'(xf.num[l]);
				quo_s[0][l] <= '0;
				ovf_s[0][l] <= RW'(xf.num[l]) >= (RW'(xf.den) << QB);
			end
			den_s[0] <= xf.den;
			flg_s[0] <= {xf.neg_x, xf.neg_y, xf.clamped};
		end
	end

	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_st
		localparam int K = QB - j;
		logic [RW-1:0] dsh;
		logic [NL-1:0] ge;

		always_comb begin
			dsh = RW'(den_s[j-1]) << K;
			for (int l = 0; l < NL; l++) begin
				ge[l] = rem_s[j-1][l] >= dsh;
			end
		end

		always_ff @(posedge clk) begin
			if (en[j]) begin
				for (int l = 0; l < NL; l++) begin
					rem_s[j][l] <= ge[l] ? rem_s[j-1][l] - dsh : rem_s[j-1][l];
					quo_s[j][l] <= quo_s[j-1][l] | (QB'(ge[l]) << K);
				end
				ovf_s[j] <= ovf_s[j-1];
				den_s[j] <= den_s[j-1];
				flg_s[j] <= flg_s[j-1];
			end
		end
	end

	assign dv.quo     = quo_s[DIV_STAGES-1];
	assign dv.ovf     = ovf_s[DIV_STAGES-1];
	assign dv.neg_x   = flg_s[DIV_STAGES-1][2];
	assign dv.neg_y   = flg_s[DIV_STAGES-1][1];
	assign dv.clamped = flg_s[DIV_STAGES-1][0];

endmodule

FILE: rtl/perspective_point_projection.sv
// Perspective point projection: one world point in, one screen point out per item.
// Fully pipelined over 28 register stages (4 transform, 23 divider, 1 output); one
// item is taken every clock while the output is not stalled, and the divider takes one
// quotient bit per stage after its first. Empty stages collapse under output stall.
// The user must write configuration only while the pipeline is empty; the block
// itself does not enforce it. Depends on ppp_pkg, ppp_xform and ppp_div.
module perspective_point_projection import ppp_pkg::*; #(
	parameter int SCREEN_WIDTH    = 320,
	parameter int SCREEN_HEIGHT   = 240,
	parameter int ROAD_HALF_WIDTH = 2048
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [IN_W-1:0]  world_x,
	input  logic signed [IN_W-1:0]  world_y,
	input  logic signed [IN_W-1:0]  world_z,
	input  logic                    wrap_back,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SXY_W-1:0] screen_x,
	output logic signed [SXY_W-1:0] screen_y,
	output logic [HW_W-1:0]         half_width,
	output logic                    depth_clamped,
	output logic                    saturated
);

	localparam logic signed [SUM_W-1:0] OFF_X  = SUM_W'(8 * SCREEN_WIDTH);
	localparam logic signed [SUM_W-1:0] OFF_Y  = SUM_W'(8 * SCREEN_HEIGHT);
	localparam logic signed [SUM_W-1:0] SX_MAX = SUM_W'(524287);
	localparam logic signed [SUM_W-1:0] SX_MIN = -SUM_W'(524288);
	localparam logic [QB-1:0]           HW_MAX = QB'(524287);
	localparam longint HWC_RAW = longint'(80) * longint'(SCREEN_WIDTH)
		* longint'(ROAD_HALF_WIDTH);
	localparam logic [HW_W-1:0] HW_CLAMP = (HWC_RAW > 524287) ? HW_W'(524287)
		: HW_W'(HWC_RAW);

	cfg_t cfg_q;
	logic [NS-1:0] v_q;
	logic [NS-1:0] rdy;
	xf_t xf;
	dv_t dv;

	logic [QB:0] qinc [NL];
	logic [QB-1:0] qr [NL];
	logic signed [SUM_W-1:0] qx, qy, x_sum, y_sum;
	logic x_hi, x_lo, y_hi, y_lo, w_hi;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.camera_x   <= '0;
			cfg_q.camera_y   <= '0;
			cfg_q.camera_z   <= '0;
			cfg_q.sine       <= '0;
			cfg_q.cosine     <= TRIG_W'(16384);
			cfg_q.lap_length <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CAMERA_X: cfg_q.camera_x   <= cfg_data;
				REG_CAMERA_Y: cfg_q.camera_y   <= cfg_data;
				REG_CAMERA_Z: cfg_q.camera_z   <= cfg_data;
				REG_SINE:     cfg_q.sine       <= cfg_data[TRIG_W-1:0];
				REG_COSINE:   cfg_q.cosine     <= cfg_data[TRIG_W-1:0];
				REG_TRACK:    cfg_q.lap_length <= cfg_data[TRACK_W-1:0];
				default: ;
			endcase
		end
	end

	// a stage loads when it is empty or its contents move on
	assign rdy[NS-1] = !v_q[NS-1] || !out_stall;
	for (genvar i = 0; i < NS - 1; i++) begin : g_rdy
		assign rdy[i] = !v_q[i] || rdy[i+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (rdy[0]) begin
				v_q[0] <= in_valid;
			end
			for (int i = 1; i < NS; i++) begin
				if (rdy[i]) begin
					v_q[i] <= v_q[i-1];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = v_q[NS-1];

	ppp_xform #(
		.SCREEN_WIDTH    (SCREEN_WIDTH),
		.SCREEN_HEIGHT   (SCREEN_HEIGHT),
		.ROAD_HALF_WIDTH (ROAD_HALF_WIDTH)
	) u_xform (
		.clk       (clk),
		.en        (rdy[XF_STAGES-1:0]),
		.cfg       (cfg_q),
		.world_x   (world_x),
		.world_y   (world_y),
		.world_z   (world_z),
		.wrap_back (wrap_back),
		.xf_s4     (xf)
	);

	ppp_div u_div (
		.clk (clk),
		.en  (rdy[XF_STAGES +: DIV_STAGES]),
		.xf  (xf),
		.dv  (dv)
	);

	// round to nearest: q = (floor(2n/d) + 1) / 2
	always_comb begin
		for (int l = 0; l < NL; l++) begin
			qinc[l] = {1'b0, dv.quo[l]} + (QB+1)'(1);
			qr[l]   = qinc[l][QB:1];
		end
		qx    = $signed({{(SUM_W-QB){1'b0}}, qr[LANE_X]});
		qy    = $signed({{(SUM_W-QB){1'b0}}, qr[LANE_Y]});
		x_sum = dv.neg_x ? OFF_X - qx : OFF_X + qx;
		y_sum = dv.neg_y ? OFF_Y + qy : OFF_Y - qy;
		x_hi  = dv.ovf[LANE_X] ? !dv.neg_x : (x_sum > SX_MAX);
		x_lo  = dv.ovf[LANE_X] ? dv.neg_x : (x_sum < SX_MIN);
		y_hi  = dv.ovf[LANE_Y] ? dv.neg_y : (y_sum > SX_MAX);
		y_lo  = dv.ovf[LANE_Y] ? !dv.neg_y : (y_sum < SX_MIN);
		w_hi  = dv.ovf[LANE_W] || (qr[LANE_W] > HW_MAX);
	end

	always_ff @(posedge clk) begin
		if (rdy[NS-1]) begin
			screen_x      <= x_hi ? SXY_W'(SX_MAX) : x_lo ? SXY_W'(SX_MIN) : SXY_W'(x_sum);
			screen_y      <= y_hi ? SXY_W'(SX_MAX) : y_lo ? SXY_W'(SX_MIN) : SXY_W'(y_sum);
			half_width    <= w_hi ? HW_W'(HW_MAX) : HW_W'(qr[LANE_W]);
			depth_clamped <= dv.clamped;
			saturated     <= x_hi || x_lo || y_hi || y_lo || w_hi;
		end
	end

`ifndef NO_ASSERTIONS
	a_clamp_width: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && depth_clamped |-> half_width == HW_CLAMP)
		else $error("clamped depth gave wrong half width");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		v_q == '0 |-> !in_stall)
		else $error("empty pipeline stalls input");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(v_q[NS-2]))
		else $error("output valid without an item behind it");
`endif

endmodule

FILE: test/perspective_point_projection_test.sv
// Testbench for perspective_point_projection: random and directed world points with an
// in-line projection predictor, queued expectations, and random idling on both sides.
// Depends on ppp_pkg and the perspective_point_projection RTL.
module perspective_point_projection_test;
	import ppp_pkg::*;

	typedef struct {
		logic signed [IN_W-1:0] wx;
		logic signed [IN_W-1:0] wy;
		logic signed [IN_W-1:0] wz;
		logic                   wrap;
	} point_t;

	typedef struct {
		logic [SXY_W-1:0] sx;
		logic [SXY_W-1:0] sy;
		logic [HW_W-1:0]  hw;
		logic             clamped;
		logic             sat;
	} proj_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [IN_W-1:0] world_x = '0, world_y = '0, world_z = '0;
	logic wrap_back = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [SXY_W-1:0] screen_x, screen_y;
	logic [HW_W-1:0] half_width;
	logic depth_clamped, saturated;
	logic in_taken = 0;

	perspective_point_projection uut (.*);

	always begin
		#2 clk = 1;
		#2 clk = 0;
	end

	// shadow of the configuration registers
	longint cam_x = 0, cam_y = 0, cam_z = 0, sin_h = 0, cos_h = 16384, trk = 0;

	point_t pending_points[$];
	proj_t  expected_proj[$];
	int     errors = 0;
	int     send_idle = 0, recv_idle = 0;
	int     hold_off = 0;
	longint cycles = 0;

	function automatic longint round_div(longint n, longint d);
		longint mag, q;
		mag = n < 0 ? -n : n;
		q = (2 * mag + d) / (2 * d);
		return n < 0 ? -q : q;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi, inout logic sat);
		if (v < lo) begin
			sat = 1;
			return lo;
		end
		if (v > hi) begin
			sat = 1;
			return hi;
		end
		return v;
	endfunction

	function automatic proj_t project(point_t p);
		proj_t r;
		longint cz, dx, dy, dz, tx, tz, den, mul, x, y, w;
		logic sat;
		sat = 0;
		cz = cam_z - (p.wrap ? trk : 0);
		dx = longint'(p.wx) - cam_x;
		dy = longint'(p.wy) - cam_y;
		dz = longint'(p.wz) - cz;
		tx = dx * cos_h + dz * sin_h;
		tz = dz * cos_h - dx * sin_h;
		r.clamped = tz * 10 < 16384;
		den = r.clamped ? 16384 : tz;
		mul = r.clamped ? 10 : 1;
		x = 2560 + round_div(2560 * mul * tx, den);
		y = 1920 - round_div(1920 * mul * (dy * 16384), den);
		w = round_div(longint'(2560) * 2048 * 16384 * mul, den);
		x = clip(x, -524288, 524287, sat);
		y = clip(y, -524288, 524287, sat);
		w = clip(w, 0, 524287, sat);
		r.sx = x[SXY_W-1:0];
		r.sy = y[SXY_W-1:0];
		r.hw = w[HW_W-1:0];
		r.sat = sat;
		return r;
	endfunction

	task automatic report(string what, longint got, longint want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	task automatic write_reg(cfg_reg_t idx, longint value);
		@(negedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value[CFG_DATA_W-1:0];
		@(negedge clk);
		cfg_we <= 0;
		case (idx)
			REG_CAMERA_X: cam_x = longint'($signed(value[23:0]));
			REG_CAMERA_Y: cam_y = longint'($signed(value[23:0]));
			REG_CAMERA_Z: cam_z = longint'($signed(value[23:0]));
			REG_SINE:     sin_h = longint'($signed(value[15:0]));
			REG_COSINE:   cos_h = longint'($signed(value[15:0]));
			REG_TRACK:    trk = longint'(value[22:0]);
			default: ;
		endcase
	endtask

	task automatic wait_drained();
		while (pending_points.size() != 0 || expected_proj.size() != 0)
			@(posedge clk);
		repeat (NS + 4) @(posedge clk);
	endtask

	function automatic point_t rand_point();
		point_t p;
		p.wx = IN_W'($urandom);
		p.wy = IN_W'($urandom);
		p.wz = IN_W'($urandom);
		p.wrap = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) != 0) begin
			// points near the camera keep results in range
			p.wx = IN_W'(cam_x + $signed($urandom_range(0, 4000)) - 2000);
			p.wy = IN_W'(cam_y + $signed($urandom_range(0, 400)) - 200);
			p.wz = IN_W'(cam_z - (p.wrap ? trk : 0) + $signed($urandom_range(0, 8000)) - 500);
		end
		return p;
	endfunction

	task automatic add_point(logic signed [IN_W-1:0] x, y, z, logic w);
		point_t p;
		p.wx = x;
		p.wy = y;
		p.wz = z;
		p.wrap = w;
		pending_points.push_back(p);
	endtask

	task automatic set_camera(longint x, y, z, s, c, t);
		write_reg(REG_CAMERA_X, x);
		write_reg(REG_CAMERA_Y, y);
		write_reg(REG_CAMERA_Z, z);
		write_reg(REG_SINE, s);
		write_reg(REG_COSINE, c);
		write_reg(REG_TRACK, t);
	endtask

	// driver: the front of the queue is the item on the port until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (in_valid)
					void'(pending_points.pop_front());
				if (pending_points.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
					point_t p;
					p = pending_points[0];
					world_x <= p.wx;
					world_y <= p.wy;
					world_z <= p.wz;
					wrap_back <= p.wrap;
					in_valid <= 1;
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	// receiver
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_stall <= 1;
			end else begin
				out_stall <= $urandom_range(0, 99) < recv_idle;
			end
		end
	end

	// input acceptance: record expectation with config at that edge
	always @(posedge clk) begin
		in_taken <= arst_n && in_valid && !in_stall;
		if (arst_n && in_valid && !in_stall) begin
			point_t p;
			p.wx = world_x;
			p.wy = world_y;
			p.wz = world_z;
			p.wrap = wrap_back;
			expected_proj.push_back(project(p));
		end
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_proj.size() == 0) begin
				report("unexpected item", cycles, 0);
			end else begin
				proj_t e;
				e = expected_proj.pop_front();
				if (screen_x !== e.sx) report("screen_x", screen_x, e.sx);
				if (screen_y !== e.sy) report("screen_y", screen_y, e.sy);
				if (half_width !== e.hw) report("half_width", half_width, e.hw);
				if (depth_clamped !== e.clamped)
					report("depth_clamped", depth_clamped, e.clamped);
				if (saturated !== e.sat) report("saturated", saturated, e.sat);
			end
		end
		if (cycles > 400000) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: reset config
		add_point(0, 0, 100, 0);
		add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 1);
		add_point(24'sh800000, 24'sh800000, 24'sh800000, 0);
		add_point(100, 5, 0, 0);
		add_point(0, 0, -50, 0);
		add_point(-300, 40, 1, 0);
		add_point(5, -5, 2, 1);
		add_point(24'shFFFFFF, 0, 24'sh7FFFFF, 0);
		wait_drained();
		set_camera(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 16384, 0, 23'h7FFFFF);
		add_point(0, 0, 0, 1);
		add_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh800000, 1);
		add_point(24'sh800000, 0, 24'sh7FFFFF, 0);
		add_point(24'sh7FFFFF, 24'sh800000, 100, 0);
		wait_drained();
		set_camera(-1000, 50, 200, 16'sh8000, 16'sh7FFF, 1000);
		add_point(-1000, 50, 300, 0);
		add_point(2000, -3000, -700, 1);
		add_point(24'sh800000, 24'sh7FFFFF, 24'sh800000, 1);
		add_point(0, 0, 0, 0);
		wait_drained();
		write_reg(cfg_reg_t'(3'd6), 24'h123456);
		write_reg(cfg_reg_t'(3'd7), 24'hFFFFFF);
		set_camera(0, 0, 0, -16384, 16384, 0);
		add_point(10, 0, 10, 0);
		add_point(-10, 1, 10, 0);
		wait_drained();

		// random phases: different cameras and idling
		for (int ph = 0; ph < 6; ph++) begin
			if (ph % 3 == 0) begin
				send_idle = 16;
				recv_idle = 88;
			end else if (ph % 3 == 1) begin
				send_idle = 88;
				recv_idle = 16;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (ph == 5) begin
				set_camera($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
			end else begin
				set_camera($signed($urandom_range(0, 2000000)) - 1000000,
					$signed($urandom_range(0, 2000)) - 1000,
					$signed($urandom_range(0, 2000000)) - 1000000,
					$signed($urandom_range(0, 32768)) - 16384,
					$signed($urandom_range(0, 32768)) - 16384,
					$urandom_range(0, 8388607));
			end
			for (int i = 0; i < 150; i++)
				pending_points.push_back(rand_point());
			if (ph == 2) begin
				@(negedge clk);
				hold_off <= 200;
			end
			wait_drained();
		end

		if (errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
